@@ src/bole_pkg.sv @@
package bole_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Request codes carried in req_type.
    localparam logic [3:0] REQ_PUSH_FRONT   = 4'd0;
    localparam logic [3:0] REQ_PUSH_BACK    = 4'd1;
    localparam logic [3:0] REQ_POP_FRONT    = 4'd2;
    localparam logic [3:0] REQ_POP_BACK     = 4'd3;
    localparam logic [3:0] REQ_READ         = 4'd4;
    localparam logic [3:0] REQ_WRITE        = 4'd5;
    localparam logic [3:0] REQ_FIND         = 4'd6;
    localparam logic [3:0] REQ_REMOVE_MATCH = 4'd7;
    localparam logic [3:0] REQ_SORTED_INS   = 4'd8;
    localparam logic [3:0] REQ_CLEAR        = 4'd9;

    // Status codes reported with every result.
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_EMPTY    = 3'd1;
    localparam logic [2:0] STAT_RANGE    = 3'd2;
    localparam logic [2:0] STAT_FULL     = 3'd3;
    localparam logic [2:0] STAT_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [31:0] item_value;
        logic [6:0]  slot;
    } req_word_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [5:0]  match_pos;
        logic [6:0]  entry_count;
        logic        is_empty;
        logic [2:0]  status;
    } rsp_word_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // What a cell loads at the commit edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_LOAD
    } cell_act_t;

    // Compare results a cell captures when a request is accepted.
    typedef struct packed {
        logic ge;
        logic le;
        logic eq;
        logic hit;
    } cell_flags_t;

endpackage

@@ src/bole_cell.sv @@
module bole_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                   clk,
    input  logic                   capture,
    input  logic [DATA_WIDTH-1:0]  cmp_value,
    input  logic [6:0]             slot,
    input  bole_pkg::cell_act_t    act,
    input  logic [DATA_WIDTH-1:0]  left_data,
    input  logic [DATA_WIDTH-1:0]  right_data,
    input  logic [DATA_WIDTH-1:0]  load_value,
    output logic [DATA_WIDTH-1:0]  data,
    output bole_pkg::cell_flags_t  flags
);
    import bole_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    cell_flags_t           flags_reg;

    // The entry is compared against the incoming value when the request is taken.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            flags_reg.ge  <= (data_reg >= cmp_value);
            flags_reg.le  <= (data_reg <= cmp_value);
            flags_reg.eq  <= (data_reg == cmp_value);
            flags_reg.hit <= (int'(slot) == INDEX);
        end
    end

    always_ff @(posedge clk)
    begin
        case (act)
            CELL_HOLD:  data_reg <= data_reg;
            CELL_LEFT:  data_reg <= left_data;
            CELL_RIGHT: data_reg <= right_data;
            CELL_LOAD:  data_reg <= load_value;
            default:    data_reg <= data_reg;
        endcase
    end

    assign data  = data_reg;
    assign flags = flags_reg;

endmodule

@@ src/bounded_ordered_list_engine_top.sv @@
// Bounded ordered list engine. The list is held in a row of CAPACITY cells,
// position 0 at the front, with the count of valid entries kept beside them.
// Each request word is handled in a compare pass and a commit: at the edge
// that accepts it, every cell compares its entry against the request value
// and latches the result; then, once no older result is stalled, the control
// picks the first matching or insertion position from those flags with a
// prefix-OR across the row, every cell shifts toward its neighbor, loads the
// new value or holds, and the result word is written to the output register.
// The next request is taken only after that commit, so a new request is
// never accepted while an older one is still in the cell row. A result
// that waits in the output register does not block the next request, but a
// second result is not committed until the first has been taken. Inserts
// into a full list report list full and change nothing; pops on an empty list
// and reads or writes beyond the count are flagged likewise. There is no
// clearing pass after reset: entries beyond the count are never observed.
module bounded_ordered_list_engine_top #(
    parameter int CAPACITY   = bole_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bole_pkg::req_word_t req,
    input  logic                req_valid,
    output logic                req_stall,
    output bole_pkg::rsp_word_t rsp,
    output logic                rsp_valid,
    input  logic                rsp_stall
);
    import bole_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int PS = $clog2(CAPACITY);

    state_t state_reg, state_next;

    logic [CW-1:0]         count_reg, count_next;
    logic [3:0]            type_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [6:0]            slot_reg;

    rsp_word_t rsp_reg, rsp_next;
    logic      rsp_valid_reg, rsp_valid_next;

    logic req_take;
    logic commit;

    logic [DATA_WIDTH-1:0] req_value;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    cell_flags_t           cell_flags [CAPACITY];
    cell_act_t             cell_act [CAPACITY];

    // The request value is cut or zero-extended to the entry width.
    assign req_value = DATA_WIDTH'(req.item_value[VW-1:0]);

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;

    // The cell row. Each cell takes from its front neighbor when a gap opens
    // and from its back neighbor when one closes.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end

        bole_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .capture    (req_take),
            .cmp_value  (req_value),
            .slot       (req.slot),
            .act        (cell_act[i]),
            .left_data  (left_d),
            .right_data (right_d),
            .load_value (value_reg),
            .data       (cell_data[i]),
            .flags      (cell_flags[i])
        );
    end

    // Per-position views of the flags; the compare flags are restricted to the occupied part.
    logic [CAPACITY-1:0] occ, tail, ge_v, le_v, eq_v, hit_v;
    logic [CAPACITY-1:0] ge_pre, eq_pre, eq_first;
    logic [CAPACITY-1:0] ins_mask, ins_prev, rem_mask;
    logic                is_full, is_empty_now, head_ge, tail_le, found, slot_ok;
    logic [DATA_WIDTH-1:0] sel_data;
    logic [PS-1:0]         first_pos;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            occ[i]   = (CW'(i) < count_reg);
            ge_v[i]  = cell_flags[i].ge;
            le_v[i]  = cell_flags[i].le;
            eq_v[i]  = cell_flags[i].eq;
            hit_v[i] = cell_flags[i].hit;
        end
        ge_v = ge_v & occ;
        le_v = le_v & occ;
        eq_v = eq_v & occ;
        tail = occ & ~(occ >> 1);

        // Inclusive prefix-OR in log steps: bit i is set from the first flag on.
        ge_pre = ge_v;
        eq_pre = eq_v;
        for (int k = 0; k < PS; k++)
        begin
            ge_pre = ge_pre | (ge_pre << (1 << k));
            eq_pre = eq_pre | (eq_pre << (1 << k));
        end
        eq_first = eq_v & ~(eq_pre << 1);

        first_pos = '0;
        sel_data  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (eq_first[i])
            begin
                first_pos = first_pos | PS'(i);
            end
            if (hit_v[i])
            begin
                sel_data = sel_data | cell_data[i];
            end
        end

        is_full      = (count_reg == CW'(CAPACITY));
        is_empty_now = (count_reg == '0);
        head_ge      = ge_v[0];
        tail_le      = |(le_v & tail);
        found        = |eq_v;
        slot_ok      = (int'(slot_reg) < int'(count_reg));
    end

    // Request decode: next count, status, result fields and cell actions.
    logic       do_ins, do_rem, do_write;
    logic [2:0] stat;

    always_comb
    begin
        ins_mask = '0;
        rem_mask = '0;
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        do_write = 1'b0;
        stat     = STAT_OK;
        rsp_next = '0;
        count_next = count_reg;

        case (type_reg)
            REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_SORTED_INS:
            begin
                if (is_full)
                begin
                    stat = STAT_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                    if (type_reg == REQ_PUSH_FRONT)
                    begin
                        ins_mask = '1;
                    end
                    else if (type_reg == REQ_PUSH_BACK)
                    begin
                        ins_mask = ~occ;
                    end
                    else if (is_empty_now || head_ge)
                    begin
                        ins_mask = '1;
                    end
                    else if (tail_le)
                    begin
                        ins_mask = ~occ;
                    end
                    else
                    begin
                        ins_mask = ge_pre;
                    end
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                if (is_empty_now)
                begin
                    stat = STAT_EMPTY;
                end
                else
                begin
                    do_rem = 1'b1;
                    if (type_reg == REQ_POP_FRONT)
                    begin
                        rem_mask = '1;
                    end
                end
            end
            REQ_READ:
            begin
                if (!slot_ok)
                begin
                    stat = STAT_RANGE;
                end
                else
                begin
                    rsp_next.read_data = 32'(sel_data[VW-1:0]);
                end
            end
            REQ_WRITE:
            begin
                if (!slot_ok)
                begin
                    stat = STAT_RANGE;
                end
                else
                begin
                    do_write = 1'b1;
                end
            end
            REQ_FIND, REQ_REMOVE_MATCH:
            begin
                if (!found)
                begin
                    stat = STAT_NOTFOUND;
                end
                else
                begin
                    rsp_next.match_pos = 6'(first_pos);
                    if (type_reg == REQ_REMOVE_MATCH)
                    begin
                        do_rem   = 1'b1;
                        rem_mask = eq_pre;
                    end
                end
            end
            REQ_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                stat = STAT_OK;
            end
        endcase

        if (do_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        if (do_rem)
        begin
            count_next = count_reg - CW'(1);
        end

        rsp_next.entry_count = 7'(count_next);
        rsp_next.is_empty    = (count_next == '0);
        rsp_next.status      = stat;
    end

    assign ins_prev = {ins_mask[CAPACITY-2:0], 1'b0};

    // Controller: the commit cycle waits only while an older result is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= commit ? count_next : count_reg;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            type_reg  <= req.req_type;
            value_reg <= req_value;
            slot_reg  <= req.slot;
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        commit         = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_act[i] = CELL_HOLD;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    commit         = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (do_ins && ins_mask[i])
                        begin
                            cell_act[i] = ins_prev[i] ? CELL_LEFT : CELL_LOAD;
                        end
                        else if (do_rem && rem_mask[i])
                        begin
                            cell_act[i] = CELL_RIGHT;
                        end
                        else if (do_write && hit_v[i])
                        begin
                            cell_act[i] = CELL_LOAD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // The count never runs past the row of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // An accepted request always moves to the commit cycle.
    a_take_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> (state_reg == ST_EXEC))
        else $error("accepted request did not reach the commit cycle");

    // A commit always presents a result in the next cycle.
    a_commit_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp_valid)
        else $error("commit without a result");

    // The reported empty flag agrees with the stored count after a commit.
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (rsp.is_empty == (count_reg == '0)))
        else $error("empty flag disagrees with the count");

endmodule

@@ bench/bounded_ordered_list_engine_top_tb.sv @@
module bounded_ordered_list_engine_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bole_pkg::*;

    // The block has room for this many entries at its default size.
    localparam int LIST_DEPTH = CAPACITY_DEF;

    // A request code that the block must ignore while still answering it.
    localparam logic [3:0] REQ_UNDEFINED = 4'd15;

    // Shape of the run. The random part follows the directed table.
    localparam int RANDOM_ITEMS = 1300;
    localparam int PHASE_LEN    = 120;

    // Both sides run without any idling while these many words have passed.
    localparam int QUIET_FROM = 400;
    localparam int QUIET_TO   = 650;

    // The receiver holds off once for a long stretch, and the sender waits
    // once for the block to drain completely.
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 60;
    localparam int PAUSE_AT    = 800;

    // A request passes through the block in a compare pass and a commit, so a
    // short drain window at the end is enough to catch any stray result word.
    localparam int DRAIN_CYCLES = 10;

    // The slowest correct run never goes more than the long hold-off plus a
    // few cycles without a handshake, so this leaves a wide margin.
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        req_word_t word;
        bit        typed;
        rsp_word_t want;
    } dir_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    req_word_t req       = '0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    rsp_word_t rsp;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;

    // The shadow copy of the list, front at index zero.
    logic [31:0] shadow_list[$];

    // Results still owed by the block, oldest first.
    rsp_word_t pending_results[$];

    dir_row_t dir_table[$];

    int  mismatches  = 0;
    int  idle_cycles = 0;
    bit  stim_done   = 1'b0;
    int  received    = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;
    bit  rx_quiet;
    rsp_word_t want_word;

    bounded_ordered_list_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A result word that carries only a count and a status, as the simple
    // rows of the directed table expect.
    function automatic rsp_word_t plain_result(int n, logic [2:0] stat);
        rsp_word_t r;
        r = '0;
        r.entry_count = 7'(n);
        r.is_empty    = (n == 0);
        r.status      = stat;
        return r;
    endfunction

    function automatic dir_row_t row(logic [3:0] code, logic [31:0] value,
                                     logic [6:0] pos, bit typed, rsp_word_t want);
        dir_row_t d;
        d.word.req_type   = code;
        d.word.item_value = value;
        d.word.slot       = pos;
        d.typed           = typed;
        d.want            = want;
        return d;
    endfunction

    // Applies one request to the shadow list and returns the result word the
    // block must produce for it.
    function automatic rsp_word_t serve_request(req_word_t w);
        rsp_word_t   r;
        int          n;
        int          pos;
        logic [31:0] v;
        r   = '0;
        v   = w.item_value;
        n   = shadow_list.size();
        pos = 0;
        case (w.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_SORTED_INS:
            begin
                if (n >= LIST_DEPTH)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    if (w.req_type == REQ_PUSH_BACK)
                    begin
                        pos = n;
                    end
                    else if (w.req_type == REQ_SORTED_INS && n != 0 && shadow_list[0] < v)
                    begin
                        // The tail test comes first, even when the list is
                        // out of order further in.
                        if (shadow_list[n - 1] <= v)
                        begin
                            pos = n;
                        end
                        else
                        begin
                            while (shadow_list[pos] < v)
                                pos++;
                        end
                    end
                    shadow_list.insert(pos, v);
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                if (n == 0)
                    r.status = STAT_EMPTY;
                else if (w.req_type == REQ_POP_FRONT)
                    void'(shadow_list.pop_front());
                else
                    void'(shadow_list.pop_back());
            end
            REQ_READ, REQ_WRITE:
            begin
                if (w.slot >= n)
                    r.status = STAT_RANGE;
                else if (w.req_type == REQ_READ)
                    r.read_data = shadow_list[w.slot];
                else
                    shadow_list[w.slot] = v;
            end
            REQ_FIND, REQ_REMOVE_MATCH:
            begin
                pos = n;
                for (int i = n - 1; i >= 0; i--)
                begin
                    if (shadow_list[i] == v)
                        pos = i;
                end
                if (pos == n)
                begin
                    r.status = STAT_NOTFOUND;
                end
                else
                begin
                    r.match_pos = 6'(pos);
                    if (w.req_type == REQ_REMOVE_MATCH)
                        shadow_list.delete(pos);
                end
            end
            REQ_CLEAR:
            begin
                shadow_list.delete();
            end
            default:
            begin
            end
        endcase
        r.entry_count = 7'(shadow_list.size());
        r.is_empty    = (shadow_list.size() == 0);
        return r;
    endfunction

    // Builds one random request from the current contents of the list. The
    // run cycles through a growing, a mixed and a shrinking phase so that the
    // list is driven to full and back to empty many times.
    function automatic req_word_t next_random_word(int idx);
        req_word_t w;
        int        n;
        int        phase;
        int        dice;
        n     = shadow_list.size();
        phase = (idx / PHASE_LEN) % 3;

        if (n > 0 && $urandom_range(0, 3) != 0)
            w.slot = 7'($urandom_range(0, n - 1));
        else
            w.slot = 7'($urandom_range(0, 127));

        // Small values give plenty of duplicates, stored values give hits
        // for find and remove, and the rest covers every bit.
        dice = $urandom_range(0, 99);
        if (dice < 35)
            w.item_value = 32'($urandom_range(0, 15));
        else if (dice < 60 && n > 0)
            w.item_value = shadow_list[$urandom_range(0, n - 1)];
        else if (dice < 70)
        begin
            case ($urandom_range(0, 3))
                0:       w.item_value = 32'h0000_0000;
                1:       w.item_value = 32'hFFFF_FFFF;
                2:       w.item_value = 32'h8000_0000;
                default: w.item_value = 32'h7FFF_FFFF;
            endcase
        end
        else
            w.item_value = $urandom;

        dice = $urandom_range(0, 99);
        if (phase == 0)
        begin
            if (dice < 35)      w.req_type = REQ_SORTED_INS;
            else if (dice < 55) w.req_type = REQ_PUSH_FRONT;
            else if (dice < 75) w.req_type = REQ_PUSH_BACK;
            else if (dice < 85) w.req_type = REQ_READ;
            else if (dice < 90) w.req_type = REQ_WRITE;
            else if (dice < 95) w.req_type = REQ_FIND;
            else                w.req_type = REQ_POP_BACK;
        end
        else if (phase == 1)
        begin
            if (dice < 12)      w.req_type = REQ_PUSH_FRONT;
            else if (dice < 24) w.req_type = REQ_PUSH_BACK;
            else if (dice < 36) w.req_type = REQ_SORTED_INS;
            else if (dice < 46) w.req_type = REQ_POP_FRONT;
            else if (dice < 56) w.req_type = REQ_POP_BACK;
            else if (dice < 66) w.req_type = REQ_READ;
            else if (dice < 74) w.req_type = REQ_WRITE;
            else if (dice < 84) w.req_type = REQ_FIND;
            else if (dice < 94) w.req_type = REQ_REMOVE_MATCH;
            else if (dice < 96) w.req_type = REQ_CLEAR;
            else                w.req_type = 4'($urandom_range(10, 15));
        end
        else
        begin
            if (dice < 25)      w.req_type = REQ_POP_FRONT;
            else if (dice < 50) w.req_type = REQ_POP_BACK;
            else if (dice < 70) w.req_type = REQ_REMOVE_MATCH;
            else if (dice < 80) w.req_type = REQ_FIND;
            else if (dice < 90) w.req_type = REQ_READ;
            else if (dice < 95) w.req_type = REQ_SORTED_INS;
            else if (dice < 98) w.req_type = REQ_WRITE;
            else                w.req_type = REQ_CLEAR;
        end
        return w;
    endfunction

    // Counts a mismatch and prints one line for it.
    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch in %s at word %0d, %0t: got %h, want %h",
                 what, received, $realtime, got, want);
    endtask

    // Sender. It walks the directed table and then the random part, and it
    // predicts each word at the edge that accepts it. Because prediction
    // happens here, every new random word is drawn from the list as it
    // stands after all accepted words.
    initial
    begin : sender
        req_word_t next_word;
        rsp_word_t predicted;
        rsp_word_t cur_want;
        bit        cur_typed;
        bit        pause_done;
        bit        quiet;
        int        taken;
        int        total;

        // Rows read off at a glance carry their expected word; the rest are
        // left to the predictor.
        dir_table.push_back(row(REQ_POP_FRONT, 32'h0, 7'd0, 1'b1, plain_result(0, STAT_EMPTY)));
        dir_table.push_back(row(REQ_POP_BACK, 32'h0, 7'd0, 1'b1, plain_result(0, STAT_EMPTY)));
        dir_table.push_back(row(REQ_READ, 32'h0, 7'd0, 1'b1, plain_result(0, STAT_RANGE)));
        dir_table.push_back(row(REQ_WRITE, 32'hFFFF_FFFF, 7'd127, 1'b1,
                                plain_result(0, STAT_RANGE)));
        dir_table.push_back(row(REQ_FIND, 32'h0, 7'd0, 1'b1, plain_result(0, STAT_NOTFOUND)));
        dir_table.push_back(row(REQ_REMOVE_MATCH, 32'hFFFF_FFFF, 7'd0, 1'b1,
                                plain_result(0, STAT_NOTFOUND)));
        dir_table.push_back(row(REQ_SORTED_INS, 32'd100, 7'd0, 1'b1, plain_result(1, STAT_OK)));
        dir_table.push_back(row(REQ_SORTED_INS, 32'hFFFF_FFFF, 7'd0, 1'b0, '0));
        dir_table.push_back(row(REQ_SORTED_INS, 32'h0, 7'd0, 1'b0, '0));
        dir_table.push_back(row(REQ_SORTED_INS, 32'd100, 7'd0, 1'b0, '0));
        dir_table.push_back(row(REQ_SORTED_INS, 32'd50, 7'd0, 1'b0, '0));
        dir_table.push_back(row(REQ_PUSH_FRONT, 32'hFFFF_FFFF, 7'd0, 1'b0, '0));
        dir_table.push_back(row(REQ_PUSH_BACK, 32'h0, 7'd0, 1'b0, '0));
        dir_table.push_back(row(REQ_READ, 32'h0, 7'd0, 1'b0, '0));
        dir_table.push_back(row(REQ_READ, 32'h0, 7'd127, 1'b1, plain_result(7, STAT_RANGE)));
        dir_table.push_back(row(REQ_READ, 32'h0, 7'd7, 1'b1, plain_result(7, STAT_RANGE)));
        dir_table.push_back(row(REQ_READ, 32'h0, 7'd6, 1'b0, '0));
        dir_table.push_back(row(REQ_WRITE, 32'hA5A5_A5A5, 7'd6, 1'b0, '0));
        dir_table.push_back(row(REQ_FIND, 32'd100, 7'd0, 1'b0, '0));
        dir_table.push_back(row(REQ_REMOVE_MATCH, 32'd100, 7'd0, 1'b0, '0));
        dir_table.push_back(row(REQ_FIND, 32'd12345, 7'd0, 1'b1,
                                plain_result(6, STAT_NOTFOUND)));
        dir_table.push_back(row(REQ_UNDEFINED, 32'hFFFF_FFFF, 7'd127, 1'b1,
                                plain_result(6, STAT_OK)));
        dir_table.push_back(row(REQ_POP_FRONT, 32'h0, 7'd0, 1'b0, '0));
        dir_table.push_back(row(REQ_POP_BACK, 32'h0, 7'd0, 1'b0, '0));
        dir_table.push_back(row(REQ_CLEAR, 32'h0, 7'd0, 1'b1, plain_result(0, STAT_OK)));

        taken      = 0;
        total      = dir_table.size() + RANDOM_ITEMS;
        pause_done = 1'b0;
        cur_typed  = 1'b0;
        cur_want   = '0;

        wait (rst_n === 1'b1);
        while (taken < total)
        begin
            @(posedge clk);
            if (req_valid && !req_stall)
            begin
                predicted = serve_request(req);
                pending_results.push_back(cur_typed ? cur_want : predicted);
                taken++;
            end
            quiet = (taken >= QUIET_FROM && taken < QUIET_TO);

            if (req_valid && req_stall)
            begin
                // The word is held unchanged until the block takes it.
            end
            else if (taken == total)
            begin
                req_valid <= 1'b0;
            end
            else if (taken == PAUSE_AT && !pause_done)
            begin
                // Wait with valid low until every owed result has come back.
                req_valid <= 1'b0;
                if (pending_results.size() == 0)
                    pause_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < 11)
            begin
                req_valid <= 1'b0;
            end
            else
            begin
                if (taken < dir_table.size())
                begin
                    next_word = dir_table[taken].word;
                    cur_typed = dir_table[taken].typed;
                    cur_want  = dir_table[taken].want;
                end
                else
                begin
                    next_word = next_random_word(taken - dir_table.size());
                    cur_typed = 1'b0;
                end
                req       <= next_word;
                req_valid <= 1'b1;
            end
        end
        stim_done = 1'b1;
    end

    // Receiver. It checks each accepted word against the oldest expectation,
    // field by field, and then picks its stall for the next cycle. Once, it
    // holds off long enough for the block to fill and stall its input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    flag_mismatch("unexpected word", rsp.read_data, 32'h0);
                end
                else
                begin
                    want_word = pending_results.pop_front();
                    if (rsp.read_data !== want_word.read_data)
                        flag_mismatch("read_data", rsp.read_data, want_word.read_data);
                    if (rsp.match_pos !== want_word.match_pos)
                        flag_mismatch("match_pos", 32'(rsp.match_pos), 32'(want_word.match_pos));
                    if (rsp.entry_count !== want_word.entry_count)
                        flag_mismatch("entry_count", 32'(rsp.entry_count),
                                      32'(want_word.entry_count));
                    if (rsp.is_empty !== want_word.is_empty)
                        flag_mismatch("is_empty", 32'(rsp.is_empty), 32'(want_word.is_empty));
                    if (rsp.status !== want_word.status)
                        flag_mismatch("status", 32'(rsp.status), 32'(want_word.status));
                end
                received++;
            end

            rx_quiet = (received >= QUIET_FROM && received < QUIET_TO);
            if (received == HOLD_AT && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= (!rx_quiet && $urandom_range(0, 99) < 11);
            end
        end
    end

    // Watchdog. Any cycle with a handshake on either side restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("[bounded_ordered_list_engine_top] ERROR");
                    $finish;
                end
            end
        end
    end

    // Reset once, then wait for the stimulus to finish and the block to
    // drain. A missing result keeps the wait going until the watchdog fires.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[bounded_ordered_list_engine_top] OK");
        else
            $display("[bounded_ordered_list_engine_top] ERROR");
        $finish;
    end

endmodule
